// ----- src/ascprf_pkg.sv -----
package ascprf_pkg;

  typedef logic [63:0] word_t;
  typedef logic [4:0][63:0] state_t;

  localparam int ROUNDS = 12;
  localparam int CNT_W = $clog2(ROUNDS);
  localparam int CFG_INDEX_W = 8;

  localparam word_t IV = 64'h80808c0000000000;
  localparam word_t PAD = 64'h8000000000000000;
  localparam word_t DOMAIN_SEP = 64'h0000000000000001;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 8'd1;

  localparam logic [7:0] ROUND_CONST [ROUNDS] = '{
    8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5, 8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
  };

  typedef struct packed {
    logic busy;
    logic ready;
  } key_status_t;

  function automatic word_t rotr(word_t v, int r);
    return (v >> r) | (v << (64 - r));
  endfunction

  function automatic state_t ascprf_round(state_t s, logic [7:0] rc);
    state_t x;
    state_t a;
    state_t y;
    x = s;
    x[2] = x[2] ^ {56'd0, rc};
    // substitution layer
    x[0] = x[0] ^ x[4];
    x[4] = x[4] ^ x[3];
    x[2] = x[2] ^ x[1];
    a[0] = x[0] ^ (~x[1] & x[2]);
    a[1] = x[1] ^ (~x[2] & x[3]);
    a[2] = x[2] ^ (~x[3] & x[4]);
    a[3] = x[3] ^ (~x[4] & x[0]);
    a[4] = x[4] ^ (~x[0] & x[1]);
    a[1] = a[1] ^ a[0];
    a[0] = a[0] ^ a[4];
    a[3] = a[3] ^ a[2];
    a[2] = ~a[2];
    // linear diffusion layer
    y[0] = a[0] ^ rotr(a[0], 19) ^ rotr(a[0], 28);
    y[1] = a[1] ^ rotr(a[1], 61) ^ rotr(a[1], 39);
    y[2] = a[2] ^ rotr(a[2], 1) ^ rotr(a[2], 6);
    y[3] = a[3] ^ rotr(a[3], 10) ^ rotr(a[3], 17);
    y[4] = a[4] ^ rotr(a[4], 7) ^ rotr(a[4], 41);
    return y;
  endfunction

endpackage

// ----- src/ascon_prf_64bit_word.sv -----
// a word accepted passes through every stage register, one round per stage, to tag_word
// throughput: one word per cycle in the 12-stage pipeline if not stalled; stalls fill bubbles
// the key-only first permutation is cached and rebuilt by an iterative unit
// reset: keys clear to zero, pipeline empties, then the cache is rebuilt with data_ready low
// every key write also rebuilds the cache, holding data_ready low while it runs
module ascon_prf_64bit_word (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ascprf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [63:0]                          cfg_data,
  input  logic                                 data_valid,
  output logic                                 data_ready,
  input  logic [63:0]                          data_word,
  output logic                                 tag_valid,
  input  logic                                 tag_ready,
  output logic [63:0]                          tag_word
);
  import ascprf_pkg::*;

  word_t       key_low;
  word_t       key_high;
  logic        rekey;
  key_status_t key_status;
  state_t      key_state;
  state_t      absorbed;

  logic        vld_s [ROUNDS];
  state_t      st_s [ROUNDS];
  logic        en_s [ROUNDS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      rekey <= 1'b1;
    end else begin
      rekey <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KEY_LOW:  key_low <= cfg_data;
          REG_KEY_HIGH: key_high <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  ascprf_key_perm u_key_perm (
    .clk       (clk),
    .rst       (rst),
    .start     (rekey),
    .key_low   (key_low),
    .key_high  (key_high),
    .status    (key_status),
    .key_state (key_state)
  );

  always_comb begin
    absorbed = key_state;
    absorbed[0] = key_state[0] ^ data_word;
    absorbed[1] = key_state[1] ^ PAD;
    absorbed[4] = key_state[4] ^ DOMAIN_SEP;
  end

  assign en_s[ROUNDS] = tag_ready;

  for (genvar i = 0; i < ROUNDS; i++) begin : g_stage
    if (i == 0) begin : g_first
      ascprf_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .vld_in   (data_valid && key_status.ready),
        .state_in (absorbed),
        .rc       (ROUND_CONST[i]),
        .en_next  (en_s[i+1]),
        .en       (en_s[i]),
        .vld      (vld_s[i]),
        .state    (st_s[i])
      );
    end else begin : g_rest
      ascprf_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .vld_in   (vld_s[i-1]),
        .state_in (st_s[i-1]),
        .rc       (ROUND_CONST[i]),
        .en_next  (en_s[i+1]),
        .en       (en_s[i]),
        .vld      (vld_s[i]),
        .state    (st_s[i])
      );
    end
  end

  assign data_ready = en_s[0] && key_status.ready;
  assign tag_valid = vld_s[ROUNDS-1];
  assign tag_word = st_s[ROUNDS-1][0];

  a_no_accept_while_rekey: assert property (@(posedge clk) disable iff (rst)
    key_status.busy || rekey |-> !data_ready)
    else $error("word accepted while key cache stale");

  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> rekey ##1 key_status.busy)
    else $error("key write did not rebuild cache");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    tag_valid && !tag_ready |=> tag_valid)
    else $error("pending tag dropped");

endmodule

// ----- src/ascprf_key_perm.sv -----
module ascprf_key_perm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ascprf_pkg::word_t    key_low,
  input  ascprf_pkg::word_t    key_high,
  output ascprf_pkg::key_status_t status,
  output ascprf_pkg::state_t   key_state
);
  import ascprf_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  state_t           state;
  state_t           init;

  always_comb begin
    init = '0;
    init[0] = IV;
    init[1] = key_low;
    init[2] = key_high;
  end

  // one round per cycle over the key-only half of the permutation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(ROUNDS - 1)) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      state <= init;
    end else if (busy) begin
      state <= ascprf_round(state, ROUND_CONST[cnt]);
    end
  end

  assign status.busy = busy;
  assign status.ready = !busy && !start;
  assign key_state = state;

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && cnt == '0)
    else $error("key permutation did not restart");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt < CNT_W'(ROUNDS))
    else $error("round counter out of range");

  a_runs_to_end: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt != CNT_W'(ROUNDS - 1) |=> busy && cnt == $past(cnt) + 1'b1)
    else $error("key permutation stopped early");

  a_finishes: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == CNT_W'(ROUNDS - 1) |=> !busy)
    else $error("key permutation overran");

endmodule

// ----- src/ascprf_stage.sv -----
module ascprf_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               vld_in,
  input  ascprf_pkg::state_t state_in,
  input  logic [7:0]         rc,
  input  logic               en_next,
  output logic               en,
  output logic               vld,
  output ascprf_pkg::state_t state
);
  import ascprf_pkg::*;

  // a stage takes new data when empty or when its contents move on
  assign en = !vld || en_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state <= ascprf_round(state_in, rc);
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  import ascprf_pkg::CFG_INDEX_W;
  import ascprf_pkg::REG_KEY_LOW;
  import ascprf_pkg::REG_KEY_HIGH;

  typedef logic [63:0] lane_t;
  typedef logic [4:0][63:0] sponge_t;

  typedef enum logic [1:0] {
    ROW_DATA,
    ROW_KEY_LOW,
    ROW_KEY_HIGH,
    ROW_KEY_BAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    lane_t     value;
  } script_row_t;

  localparam lane_t START_IV = 64'h80808c0000000000;
  localparam lane_t PAD_BIT = 64'h8000000000000000;
  localparam lane_t ONES = 64'hffffffffffffffff;
  localparam logic [CFG_INDEX_W-1:0] BAD_INDEX = 8'hff;
  localparam int SCRIPT_LEN = 24;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 75;
  localparam int SETTLE_CYCLES = 20;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;
  logic                   data_valid;
  logic                   data_ready;
  logic [63:0]            data_word;
  logic                   tag_valid;
  logic                   tag_ready;
  logic [63:0]            tag_word;

  lane_t pending_tags [$];
  lane_t key_lo_copy;
  lane_t key_hi_copy;
  lane_t want_tag;
  int    fail_count;
  int    words_sent;
  int    tags_checked;
  int    key_writes;
  bit    src_idle;
  bit    sink_idle;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_DATA,     64'h0},
    '{ROW_DATA,     ONES},
    '{ROW_DATA,     64'h1},
    '{ROW_DATA,     64'h8000000000000000},
    '{ROW_DATA,     64'h5555555555555555},
    '{ROW_DATA,     64'haaaaaaaaaaaaaaaa},
    '{ROW_KEY_BAD,  ONES},
    '{ROW_DATA,     64'h0},
    '{ROW_KEY_LOW,  ONES},
    '{ROW_DATA,     64'h0},
    '{ROW_DATA,     ONES},
    '{ROW_KEY_HIGH, ONES},
    '{ROW_DATA,     64'h0},
    '{ROW_DATA,     64'h0123456789abcdef},
    '{ROW_KEY_LOW,  64'h0},
    '{ROW_DATA,     64'h0},
    '{ROW_KEY_LOW,  64'h0706050403020100},
    '{ROW_KEY_HIGH, 64'h0f0e0d0c0b0a0908},
    '{ROW_DATA,     64'h0},
    '{ROW_DATA,     ONES},
    '{ROW_DATA,     64'hfedcba9876543210},
    '{ROW_KEY_LOW,  64'h0},
    '{ROW_KEY_HIGH, 64'h0},
    '{ROW_DATA,     64'h80}
  };

  ascon_prf_64bit_word i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_word  (data_word),
    .tag_valid  (tag_valid),
    .tag_ready  (tag_ready),
    .tag_word   (tag_word)
  );

  function automatic lane_t ror(lane_t v, int n);
    logic [127:0] wide;
    wide = {v, v} >> n;
    return wide[63:0];
  endfunction

  function automatic sponge_t ascon_round(sponge_t s, logic [7:0] rc);
    sponge_t t;
    s[2] = s[2] ^ {56'd0, rc};
    s[0] = s[0] ^ s[4];
    s[4] = s[4] ^ s[3];
    s[2] = s[2] ^ s[1];
    // chi-like sbox across the five lanes
    for (int i = 0; i < 5; i++) begin
      t[i] = s[i] ^ (~s[(i + 1) % 5] & s[(i + 2) % 5]);
    end
    t[1] = t[1] ^ t[0];
    t[0] = t[0] ^ t[4];
    t[3] = t[3] ^ t[2];
    t[2] = ~t[2];
    s[0] = t[0] ^ ror(t[0], 19) ^ ror(t[0], 28);
    s[1] = t[1] ^ ror(t[1], 61) ^ ror(t[1], 39);
    s[2] = t[2] ^ ror(t[2], 1) ^ ror(t[2], 6);
    s[3] = t[3] ^ ror(t[3], 10) ^ ror(t[3], 17);
    s[4] = t[4] ^ ror(t[4], 7) ^ ror(t[4], 41);
    return s;
  endfunction

  function automatic sponge_t permute12(sponge_t s);
    // round constants run f0, e1, d2 ... 4b: high nibble counts down, low counts up
    for (int r = 0; r < 12; r++) begin
      s = ascon_round(s, {4'(15 - r), 4'(r)});
    end
    return s;
  endfunction

  function automatic lane_t prf_tag(lane_t w);
    sponge_t s;
    s[0] = START_IV;
    s[1] = key_lo_copy;
    s[2] = key_hi_copy;
    s[3] = '0;
    s[4] = '0;
    s = permute12(s);
    s[0] = s[0] ^ w;
    s[1] = s[1] ^ PAD_BIT;
    s[4] = s[4] ^ 64'd1;
    s = permute12(s);
    return s[0];
  endfunction

  function automatic lane_t pick_word();
    int bitpos;
    bitpos = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      2: return 64'd1 << bitpos;
      3: return ~(64'd1 << bitpos);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(lane_t w);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    data_valid <= 1'b1;
    data_word  <= w;
    do @(posedge clk); while (!data_ready);
    pending_tags.push_back(prf_tag(w));
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, lane_t v);
    @(negedge clk);
    data_valid <= 1'b0;
    cfg_valid  <= 1'b0;
    // keys change only with the pipeline empty
    while (pending_tags.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_KEY_LOW) begin
      key_lo_copy = v;
    end else if (idx == REG_KEY_HIGH) begin
      key_hi_copy = v;
    end
    key_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // sink side back-pressure
  initial begin
    tag_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (sink_idle && $urandom_range(0, 5) == 0) begin
        tag_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        tag_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && tag_valid && tag_ready) begin
      if (pending_tags.size() == 0) begin
        $error("tag_word transfer with nothing pending: actual %h", tag_word);
        fail_count++;
      end else begin
        want_tag = pending_tags.pop_front();
        if (tag_word !== want_tag) begin
          $error("tag_word mismatch: expected %h, actual %h", want_tag, tag_word);
          fail_count++;
        end
      end
      tags_checked++;
    end
  end

  initial begin
    lane_t lo;
    lane_t hi;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    data_valid  = 1'b0;
    data_word   = '0;
    key_lo_copy = '0;
    key_hi_copy = '0;
    fail_count  = 0;
    words_sent  = 0;
    tags_checked = 0;
    key_writes  = 0;
    src_idle    = 1'b1;
    sink_idle   = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      case (script[i].kind)
        ROW_DATA:     send_word(script[i].value);
        ROW_KEY_LOW:  write_reg(REG_KEY_LOW, script[i].value);
        ROW_KEY_HIGH: write_reg(REG_KEY_HIGH, script[i].value);
        ROW_KEY_BAD:  write_reg(BAD_INDEX, script[i].value);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // idle-free stretches on one side or the other, none at all in the last phase
      src_idle  = (ph != 1 && ph != PHASES - 1);
      sink_idle = (ph != 3 && ph != PHASES - 1);
      case (ph)
        1: begin lo = '0;   hi = ONES; end
        2: begin lo = ONES; hi = ONES; end
        4: begin lo = {$urandom, $urandom}; hi = '0; end
        default: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_INDEX_W'($urandom_range(2, 255)), {$urandom, $urandom});
      end
      write_reg(REG_KEY_LOW, lo);
      write_reg(REG_KEY_HIGH, hi);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(pick_word());
      end
    end

    @(negedge clk);
    data_valid <= 1'b0;
    cfg_valid  <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d data words under %0d key register writes (out-of-range indexes too)",
             words_sent, key_writes);
    $display("checked %0d tags, %0d failures", tags_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
